// ===== hdl/lcva_pkg.sv =====
// ---------------------------------------------------------------------------
// Load-cell volume averager package
// Shared widths, reset values, command and register codes, divider request.
// ---------------------------------------------------------------------------
package lcva_pkg;

	localparam int DATA_W    = 32;
	localparam int VOL_W     = 16;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 8;
	localparam int OUT_W     = VOL_W + DATA_W + DATA_W;
	localparam int DIV_CNT_W = $clog2(DATA_W + 1);

	localparam logic [DATA_W-1:0] SIGN_FLIP       = 32'h8000_0000;
	localparam logic [DATA_W-1:0] RST_ZERO_OFFSET = 32'd2079150000;
	localparam logic [DATA_W-1:0] RST_START_COEF  = 32'd56450;
	localparam logic [VOL_W-1:0]  RST_FULL_VOLUME = 16'd11500;
	localparam logic [VOL_W-1:0]  RST_MAX_VOLUME  = 16'd65535;

	// Command codes carried in the input tuser field.
	localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP       = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_COEF  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLUME = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME  = 8'd3;

	// Request from the sequencer to the bit-serial divider.
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== hdl/lcva_divider.sv =====
// ---------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division that develops one quotient bit per clock cycle.
// ---------------------------------------------------------------------------
module lcva_divider (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lcva_pkg::div_req_t                      req,
	output logic [lcva_pkg::DATA_W-1:0]             quotient,
	output logic                                    done
);

	logic [lcva_pkg::DATA_W-1:0]    rem_q;
	logic [lcva_pkg::DATA_W-1:0]    quo_q;
	logic [lcva_pkg::DATA_W-1:0]    dvs_q;
	logic [lcva_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [lcva_pkg::DATA_W:0]      shifted;
	logic [lcva_pkg::DATA_W+1:0]    diff;

	// The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
	// A zero divisor never borrows, so the quotient saturates to all ones.
	assign shifted = {rem_q, quo_q[lcva_pkg::DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= lcva_pkg::DIV_CNT_W'(lcva_pkg::DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lcva_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[lcva_pkg::DATA_W+1]) begin
				rem_q <= diff[lcva_pkg::DATA_W-1:0];
				quo_q <= {quo_q[lcva_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[lcva_pkg::DATA_W-1:0];
				quo_q <= {quo_q[lcva_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hdl/load_cell_volume_averager_unit.sv =====
// ---------------------------------------------------------------------------
// Load-cell volume averager
// Converts converter words into volume, keeps a running average and
// calibrates the counts-per-volume coefficient at tank overflow.
// ---------------------------------------------------------------------------
// An invalid sample or unused command goes from idle straight to the output stage; a sample,
// read or calibration steps through its working states and waits on the bit-serial divider
// when it needs a quotient. One item is in work at a time, so no new item is taken until the
// last one is done, and the next is taken while a result waits.
// Reset is asynchronous and active low: configuration returns to its defaults, the
// running coefficient to its start value, all other state and the output to empty.
module load_cell_volume_averager_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lcva_pkg::DATA_W-1:0]        s_tdata,   // [31:0] raw_word
	input  logic [lcva_pkg::CMD_W-1:0]         s_tuser,   // [1:0] cmd
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lcva_pkg::OUT_W-1:0]         m_tdata,   // [15:0] volume,
	                                                      // [47:16] offset_reading,
	                                                      // [79:48] coef_now
	output logic                               m_tuser,   // [0] accepted
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lcva_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcva_pkg::DATA_W-1:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUB,
		ST_SDIV,
		ST_SLIM,
		ST_SACC,
		ST_RD,
		ST_RDIV,
		ST_CAL,
		ST_CDIV,
		ST_CLO,
		ST_CHI,
		ST_CAVG,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers. The start coefficient is only ever used to reload
	// the running coefficient, so it needs no register of its own.
	logic [lcva_pkg::DATA_W-1:0] zero_offset_q;
	logic [lcva_pkg::VOL_W-1:0]  full_volume_q;
	logic [lcva_pkg::VOL_W-1:0]  max_volume_q;

	// Block state.
	logic [lcva_pkg::DATA_W-1:0] last_offset_q;
	logic [lcva_pkg::DATA_W-1:0] net_q;
	logic [lcva_pkg::DATA_W-1:0] sum_q;
	logic [lcva_pkg::DATA_W-1:0] count_q;
	logic [lcva_pkg::DATA_W-1:0] coef_q;
	logic [lcva_pkg::DATA_W-1:0] cal_avg_q;

	// Per-item working registers.
	logic [lcva_pkg::DATA_W-1:0] word_q;
	logic [lcva_pkg::DATA_W-1:0] quo_q;
	logic [lcva_pkg::VOL_W-1:0]  vol_q;
	logic                        acc_q;
	logic                        lo_ok_q;

	// Output register.
	logic                        m_tvalid_q;
	logic [lcva_pkg::OUT_W-1:0]  m_tdata_q;
	logic                        m_tuser_q;

	// Divider interface.
	lcva_pkg::div_req_t          div_req;
	logic [lcva_pkg::DATA_W-1:0] div_quo;
	logic                        div_done;

	// Datapath terms.
	logic [lcva_pkg::DATA_W-1:0] reading;
	logic                        above_zero;
	logic [lcva_pkg::DATA_W-1:0] coef_sixteenth;
	logic [lcva_pkg::DATA_W:0]   cal_sum;
	logic                        in_accept;
	logic                        out_free;

	assign in_accept  = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;

	// Flipping the sign bit turns the two's complement word into offset binary.
	assign reading        = word_q ^ lcva_pkg::SIGN_FLIP;
	assign above_zero     = reading > zero_offset_q;
	assign coef_sixteenth = coef_q >> 4;
	assign cal_sum        = {1'b0, cal_avg_q} + {1'b0, quo_q};

	// The divider is shared by the sample, read and calibration paths.
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_SUB: begin
				div_req.start    = above_zero;
				div_req.dividend = reading - zero_offset_q;
				div_req.divisor  = coef_q;
			end
			ST_RD: begin
				div_req.start    = count_q > lcva_pkg::DATA_W'(1);
				div_req.dividend = sum_q;
				div_req.divisor  = count_q;
			end
			ST_CAL: begin
				div_req.start    = (full_volume_q != '0) && (net_q != '0);
				div_req.dividend = net_q;
				div_req.divisor  = {{(lcva_pkg::DATA_W-lcva_pkg::VOL_W){1'b0}}, full_volume_q};
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	lcva_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			zero_offset_q <= lcva_pkg::RST_ZERO_OFFSET;
			full_volume_q <= lcva_pkg::RST_FULL_VOLUME;
			max_volume_q  <= lcva_pkg::RST_MAX_VOLUME;
			last_offset_q <= '0;
			net_q         <= '0;
			sum_q         <= '0;
			count_q       <= '0;
			coef_q        <= lcva_pkg::RST_START_COEF;
			cal_avg_q     <= '0;
			m_tvalid_q    <= 1'b0;
			word_q        <= '0;
			quo_q         <= '0;
			vol_q         <= '0;
			acc_q         <= 1'b0;
			lo_ok_q       <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= 1'b0;
		end else begin
			// A result that is taken while the next one is being loaded is replaced below.
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			// Configuration writes arrive only while the block is idle.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lcva_pkg::REG_ZERO_OFFSET: zero_offset_q <= cfg_data;
					lcva_pkg::REG_START_COEF:  coef_q        <= cfg_data;
					lcva_pkg::REG_FULL_VOLUME: full_volume_q <= cfg_data[lcva_pkg::VOL_W-1:0];
					lcva_pkg::REG_MAX_VOLUME:  max_volume_q  <= cfg_data[lcva_pkg::VOL_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						word_q <= s_tdata;
						vol_q  <= '0;
						acc_q  <= 1'b0;
						unique case (s_tuser)
							lcva_pkg::CMD_SAMPLE: begin
								// A set low bit marks a word the converter did not finish.
								state_q <= s_tdata[0] ? ST_DONE : ST_SUB;
							end
							lcva_pkg::CMD_READ:      state_q <= ST_RD;
							lcva_pkg::CMD_CALIBRATE: state_q <= ST_CAL;
							default:                 state_q <= ST_DONE;
						endcase
					end
				end
				ST_SUB: begin
					last_offset_q <= reading;
					if (above_zero) begin
						net_q   <= reading - zero_offset_q;
						state_q <= ST_SDIV;
					end else begin
						net_q   <= '0;
						quo_q   <= '0;
						state_q <= ST_SACC;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= ST_SLIM;
					end
				end
				ST_SLIM: begin
					// Above the limit the volume becomes one less than the limit, or zero
					// when the limit itself is zero.
					if (quo_q > {{(lcva_pkg::DATA_W-lcva_pkg::VOL_W){1'b0}}, max_volume_q}) begin
						if (max_volume_q != '0) begin
							quo_q <= {{(lcva_pkg::DATA_W-lcva_pkg::VOL_W){1'b0}},
								max_volume_q - 1'b1};
						end else begin
							quo_q <= '0;
						end
					end
					state_q <= ST_SACC;
				end
				ST_SACC: begin
					sum_q   <= sum_q + quo_q;
					count_q <= count_q + 1'b1;
					vol_q   <= quo_q[lcva_pkg::VOL_W-1:0];
					acc_q   <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_RD: begin
					if (count_q > lcva_pkg::DATA_W'(1)) begin
						state_q <= ST_RDIV;
					end else begin
						vol_q   <= sum_q[lcva_pkg::VOL_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						// The average restarts as a single sample of the returned value.
						vol_q   <= div_quo[lcva_pkg::VOL_W-1:0];
						sum_q   <= {{(lcva_pkg::DATA_W-lcva_pkg::VOL_W){1'b0}},
							div_quo[lcva_pkg::VOL_W-1:0]};
						count_q <= lcva_pkg::DATA_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_CAL: begin
					if ((full_volume_q != '0) && (net_q != '0)) begin
						state_q <= ST_CDIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CDIV: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= ST_CLO;
					end
				end
				ST_CLO: begin
					lo_ok_q <= quo_q > (coef_q - coef_sixteenth);
					state_q <= ST_CHI;
				end
				ST_CHI: begin
					// Upper bound of the window is taken one bit wider so it cannot wrap.
					if (lo_ok_q &&
						({1'b0, quo_q} < ({1'b0, coef_q} + {1'b0, coef_sixteenth}))) begin
						if (cal_avg_q == '0) begin
							cal_avg_q <= quo_q;
						end
						state_q <= ST_CAVG;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CAVG: begin
					cal_avg_q <= cal_sum[lcva_pkg::DATA_W:1];
					coef_q    <= cal_sum[lcva_pkg::DATA_W:1];
					acc_q     <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {coef_q, last_offset_q, vol_q};
						m_tuser_q  <= acc_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

endmodule

// ===== hdl/lcva_checker.sv =====
// ---------------------------------------------------------------------------
// Load-cell volume averager port checker
// Watches the top-level ports for stream and sequencing rules.
// ---------------------------------------------------------------------------
module lcva_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [lcva_pkg::CMD_W-1:0]         s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [lcva_pkg::OUT_W-1:0]         m_tdata,
	input logic                               m_tuser
);

	// A waiting result holds still until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// One item is in work at a time: after an input transfer the block is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// A new result is only produced after the block has been working on an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item in work");

	// An unused command finishes without touching the block state: nothing is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == lcva_pkg::CMD_NOP) |=> ##1
		(m_tvalid && !m_tuser && (m_tdata[lcva_pkg::VOL_W-1:0] == '0)) || !m_tvalid ||
		$past(m_tvalid && !m_tready))
		else $error("unused command produced a non-empty result");

endmodule

bind load_cell_volume_averager_unit lcva_checker u_lcva_checker (.*);
